>>> src/epcl_pkg.sv
package epcl_pkg;

  // default width of the bit-time tick counter
  localparam int COUNT_WIDTH_DEF = 16;

  // reset value of the ticks-per-bit register
  localparam logic [15:0] BIT_TICKS_RST = 16'd2437;

  // operation codes of an input request
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_READ_INIT = 2'd1;
  localparam logic [1:0] OP_SEND_CFG  = 2'd2;

  // sequencer phase codes
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_WAIT_HIGH1 = 5'd1;
  localparam logic [4:0] PH_WAIT_LOW   = 5'd2;
  localparam logic [4:0] PH_WAIT_HIGH2 = 5'd3;
  localparam logic [4:0] PH_WAIT_FALL  = 5'd4;
  localparam logic [4:0] PH_SKIP_FULL  = 5'd5;
  localparam logic [4:0] PH_SKIP_HALF  = 5'd6;
  localparam logic [4:0] PH_SAMPLE     = 5'd7;
  localparam logic [4:0] PH_GAP        = 5'd8;
  localparam logic [4:0] PH_ACK        = 5'd9;
  localparam logic [4:0] PH_WRITE      = 5'd10;

  // frame counts and slot counts
  localparam logic [3:0] ACK_FRAME     = 4'd12;
  localparam logic [3:0] DATA_BITS     = 4'd8;
  localparam logic [3:0] FRAME_SLOTS   = 4'd12;
  localparam logic [3:0] PREAMBLE_SLOTS = 4'd4;
  localparam logic [3:0] ACK_SLOTS     = 4'd13;
  localparam logic [2:0] GAP_BITS      = 3'd4;
  localparam logic [7:0] TRAILER_BYTE  = 8'd11;

  // one result as it leaves the sequencer
  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        busy;
    logic        done;
    logic [15:0] received_word;
  } epcl_result_t;

  // byte carried by each send-config frame
  function automatic logic [7:0] frame_byte(input logic [3:0] f, input logic [15:0] w);
    logic [7:0] b;
    b = 8'h00;
    case (f)
      4'd0:    b = w[7:0];
      4'd1:    b = w[15:8];
      4'd2:    b = {7'd0, w[0]};
      4'd3:    b = {7'd0, w[1]};
      4'd4:    b = {7'd0, w[2]};
      4'd5:    b = {6'd0, w[4:3]};
      4'd6:    b = {6'd0, w[6:5]};
      4'd7:    b = {6'd0, w[9:8]};
      4'd8:    b = {7'd0, w[7]};
      4'd11:   b = TRAILER_BYTE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> src/epcl_seq.sv
module epcl_seq #(
  parameter int COUNT_WIDTH = epcl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [1:0]           operation,
  input  logic                 line_in,
  input  logic [15:0]          send_word,
  input  logic [15:0]          bit_ticks,
  output epcl_pkg::epcl_result_t result
);
  import epcl_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;

  logic [4:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [3:0]             frame_r, frame_nxt;
  logic [2:0]             pulse_r, pulse_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [15:0]            word_r, word_nxt;
  logic [15:0]            rx_r, rx_nxt;
  logic                   done_nxt;

  logic [15:0]            dly_target;
  logic [CMP_W-1:0]       tick_inc;
  logic                   dly_end;
  logic [COUNT_WIDTH-1:0] dly_tick;
  logic [3:0]             bit_inc;
  logic [3:0]             frame_inc;
  logic [2:0]             pulse_inc;
  logic [7:0]             shift_smp;
  logic [3:0]             slot_off;
  logic [7:0]             tx_byte;

  // delay counter shared by all timed phases
  assign dly_target = (phase_r == PH_SKIP_HALF) ? {1'b0, bit_ticks[15:1]} : bit_ticks;
  assign tick_inc   = CMP_W'(tick_r) + CMP_W'(1);
  assign dly_end    = (tick_inc >= CMP_W'(dly_target)) || (tick_r == '1);
  assign dly_tick   = dly_end ? '0 : tick_inc[COUNT_WIDTH-1:0];

  assign bit_inc   = bit_r + 4'd1;
  assign frame_inc = frame_r + 4'd1;
  assign pulse_inc = pulse_r + 3'd1;

  // data bit sampled on the first tick of its bit time
  always_comb begin
    shift_smp = shift_r;
    if ((tick_r == '0) && (bit_r < DATA_BITS)) begin
      shift_smp = shift_r | (8'(line_in) << bit_r[2:0]);
    end
  end

  // phase sequencer
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    frame_nxt = frame_r;
    pulse_nxt = pulse_r;
    shift_nxt = shift_r;
    word_nxt  = word_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        tick_nxt  = '0;
        bit_nxt   = 4'd0;
        pulse_nxt = 3'd0;
        if (operation == OP_READ_INIT) begin
          frame_nxt = 4'd0;
          phase_nxt = PH_WAIT_HIGH1;
        end else if (operation == OP_SEND_CFG) begin
          word_nxt  = send_word;
          frame_nxt = 4'd0;
          phase_nxt = PH_WRITE;
        end
      end
      PH_WAIT_HIGH1: begin
        if (line_in) phase_nxt = PH_WAIT_LOW;
      end
      PH_WAIT_LOW: begin
        if (!line_in) phase_nxt = PH_WAIT_HIGH2;
      end
      PH_WAIT_HIGH2: begin
        if (line_in) phase_nxt = PH_WAIT_FALL;
      end
      PH_WAIT_FALL: begin
        if (!line_in) begin
          shift_nxt = 8'd0;
          bit_nxt   = 4'd0;
          tick_nxt  = '0;
          phase_nxt = PH_SKIP_FULL;
        end
      end
      PH_SKIP_FULL: begin
        tick_nxt = dly_tick;
        if (dly_end) phase_nxt = PH_SKIP_HALF;
      end
      PH_SKIP_HALF: begin
        tick_nxt = dly_tick;
        if (dly_end) phase_nxt = PH_SAMPLE;
      end
      PH_SAMPLE: begin
        shift_nxt = shift_smp;
        tick_nxt  = dly_tick;
        if (dly_end) begin
          bit_nxt = bit_inc;
          if (bit_inc >= DATA_BITS) begin
            bit_nxt = 4'd0;
            if (frame_r == ACK_FRAME) begin
              // ack byte after send-config is dropped
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
              pulse_nxt = 3'd0;
              done_nxt  = 1'b1;
            end else if (frame_r == 4'd0) begin
              word_nxt  = {8'd0, shift_smp};
              frame_nxt = 4'd1;
              phase_nxt = PH_WAIT_HIGH1;
            end else begin
              rx_nxt    = {shift_smp, word_r[7:0]};
              pulse_nxt = 3'd0;
              phase_nxt = PH_GAP;
            end
          end
        end
      end
      PH_GAP: begin
        tick_nxt = dly_tick;
        if (dly_end) begin
          pulse_nxt = pulse_inc;
          if (pulse_inc >= GAP_BITS) begin
            pulse_nxt = 3'd0;
            bit_nxt   = 4'd0;
            phase_nxt = PH_ACK;
          end
        end
      end
      PH_ACK: begin
        tick_nxt = dly_tick;
        if (dly_end) begin
          bit_nxt = bit_inc;
          if (bit_inc >= ACK_SLOTS) begin
            phase_nxt = PH_IDLE;
            tick_nxt  = '0;
            bit_nxt   = 4'd0;
            pulse_nxt = 3'd0;
            done_nxt  = 1'b1;
          end
        end
      end
      PH_WRITE: begin
        tick_nxt = dly_tick;
        if (dly_end) begin
          bit_nxt = bit_inc;
          if (bit_inc >= FRAME_SLOTS) begin
            bit_nxt   = 4'd0;
            frame_nxt = frame_inc;
            if (frame_inc >= ACK_FRAME) begin
              frame_nxt = ACK_FRAME;
              phase_nxt = PH_WAIT_HIGH1;
            end
          end
        end
      end
      default: begin
        // unused phase codes fall back to idle
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
        bit_nxt   = 4'd0;
        pulse_nxt = 3'd0;
        done_nxt  = 1'b1;
      end
    endcase
  end

  // line drive for the phase being entered
  assign slot_off = bit_nxt - PREAMBLE_SLOTS;
  assign tx_byte  = frame_byte(frame_nxt, word_nxt);

  always_comb begin
    result.drive_enable  = 1'b0;
    result.drive_level   = 1'b0;
    result.busy          = (phase_nxt != PH_IDLE);
    result.done          = done_nxt;
    result.received_word = rx_nxt;
    if (phase_nxt == PH_WRITE) begin
      result.drive_enable = 1'b1;
      if (bit_nxt < PREAMBLE_SLOTS) begin
        result.drive_level = ~bit_nxt[0];
      end else begin
        result.drive_level = tx_byte[slot_off[2:0]];
      end
    end else if (phase_nxt == PH_ACK) begin
      result.drive_enable = 1'b1;
      result.drive_level  = ~bit_nxt[0];
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= 4'd0;
      frame_r <= 4'd0;
      pulse_r <= 3'd0;
      shift_r <= 8'd0;
      word_r  <= 16'd0;
      rx_r    <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      frame_r <= frame_nxt;
      pulse_r <= pulse_nxt;
      shift_r <= shift_nxt;
      word_r  <= word_nxt;
      rx_r    <= rx_nxt;
    end
  end

endmodule

>>> src/esc_program_card_link_core.sv
// Program-card link controller: each input request is one timing tick with a
// sample of the shared line, plus an optional start of a read-init or
// send-config sequence. A request is taken every clock cycle unless the output
// register is full and out_ready is low; its result (line drive, busy, done
// pulse and last received word) appears in the output register on the next
// cycle and the next request is taken in that same cycle when the output side
// is ready. All work of a tick is one pass through the phase sequencer; bit
// timing is set by bit_ticks, written via cfg while idle (the block does not enforce it).
module esc_program_card_link_core #(
  parameter int COUNT_WIDTH = epcl_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_line_in,
  input  logic [15:0] in_send_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_enable,
  output logic        out_drive_level,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [15:0] out_received_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import epcl_pkg::*;

  logic [15:0]  bit_ticks_r;
  logic         out_valid_r;
  epcl_result_t out_res_r;
  epcl_result_t seq_res;
  logic         in_take;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // bit period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r <= BIT_TICKS_RST;
    end else if (cfg_valid) begin
      bit_ticks_r <= cfg_data;
    end
  end

  epcl_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_take),
    .operation (in_operation),
    .line_in   (in_line_in),
    .send_word (in_send_word),
    .bit_ticks (bit_ticks_r),
    .result    (seq_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_enable  = out_res_r.drive_enable;
  assign out_drive_level   = out_res_r.drive_level;
  assign out_busy_res      = out_res_r.busy;
  assign out_done_res      = out_res_r.done;
  assign out_received_word = out_res_r.received_word;

`ifndef SYNTHESIS
  // a finished sequence is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // the line is only driven during a running sequence
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_enable |-> out_busy_res)
    else $error("line driven while idle");

  // an empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a taken request always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");
`endif

endmodule
